[design/atilt_pkg.sv]
// ----------------------------------------------------------------------------
// atilt_pkg: shared types and constants of the tilt angle core
// Payload structs of the channels, the words passed along the square root
// and CORDIC cell rows, and the arctangent table in units of 2^-32 turn.
// ----------------------------------------------------------------------------
package atilt_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int THRESH_W    = 15;
    localparam int PITCH_W     = 15;
    localparam int ROLL_W      = 16;

    // The root of (x*x + z*z) * 2^16 needs at most 24 bits.
    localparam int ROOT_W = SAMPLE_BITS + 8;
    localparam int RAD_W  = 2 * ROOT_W;

    localparam int VEC_W  = 28;
    localparam int ACC_W  = 34;
    localparam int HUND_W = 17;
    localparam int MAG_W  = 15;

    localparam int ATAN_TABLE_LEN = 24;

    localparam logic [THRESH_W-1:0]    THRESH_RESET  = THRESH_W'(3000);
    localparam logic [HUND_W-1:0]      PITCH_LIM     = HUND_W'(9000);
    localparam logic [HUND_W-1:0]      ROLL_LIM      = HUND_W'(18000);
    localparam logic [HUND_W-1:0]      QUARTER_HUND  = HUND_W'(9000);
    localparam logic [HUND_W-1:0]      HALF_HUND     = HUND_W'(18000);
    localparam logic [15:0]            HUND_PER_TURN = 16'd36000;
    localparam logic signed [ACC_W-1:0] QUARTER_TURN = ACC_W'(1073741824);

    typedef enum logic [2:0] {
        SPC_NONE,
        SPC_ZERO,
        SPC_HALF,
        SPC_POS_Q,
        SPC_NEG_Q
    } spc_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] accel_x;
        logic signed [SAMPLE_BITS-1:0] accel_y;
        logic signed [SAMPLE_BITS-1:0] accel_z;
    } sample_t;

    typedef struct packed {
        logic signed [PITCH_W-1:0] pitch_angle;
        logic signed [ROLL_W-1:0]  roll_angle;
        logic                      tilted;
    } result_t;

    typedef struct packed {
        logic [THRESH_W-1:0] tilt_threshold;
    } cfg_t;

    // Word carried along the square root row.
    typedef struct packed {
        logic [RAD_W-1:0]              rem;
        logic [ROOT_W-1:0]             root;
        logic signed [SAMPLE_BITS-1:0] x;
        logic signed [SAMPLE_BITS-1:0] y;
        logic signed [SAMPLE_BITS-1:0] z;
    } root_word_t;

    // One CORDIC vector with its angle accumulator.
    typedef struct packed {
        spc_t                    spc;
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [ACC_W-1:0] acc;
    } lane_t;

    typedef struct packed {
        lane_t pitch;
        lane_t roll;
    } cordic_word_t;

    function automatic logic signed [ACC_W-1:0] atan_turn(input int idx);
        logic signed [ACC_W-1:0] val;
        case (idx)
            0:       val = ACC_W'(536870912);
            1:       val = ACC_W'(316933406);
            2:       val = ACC_W'(167458907);
            3:       val = ACC_W'(85004756);
            4:       val = ACC_W'(42667331);
            5:       val = ACC_W'(21354465);
            6:       val = ACC_W'(10679838);
            7:       val = ACC_W'(5340245);
            8:       val = ACC_W'(2670163);
            9:       val = ACC_W'(1335087);
            10:      val = ACC_W'(667544);
            11:      val = ACC_W'(333772);
            12:      val = ACC_W'(166886);
            13:      val = ACC_W'(83443);
            14:      val = ACC_W'(41722);
            15:      val = ACC_W'(20861);
            16:      val = ACC_W'(10430);
            17:      val = ACC_W'(5215);
            18:      val = ACC_W'(2608);
            19:      val = ACC_W'(1304);
            20:      val = ACC_W'(652);
            21:      val = ACC_W'(326);
            22:      val = ACC_W'(163);
            23:      val = ACC_W'(81);
            default: val = '0;
        endcase
        return val;
    endfunction

    // Sets up atan2(num, den): degenerate vectors are flagged, and a vector
    // in the left half plane is turned by a quarter turn toward the x axis.
    function automatic lane_t prep_lane(input logic signed [VEC_W-1:0] num,
                                        input logic signed [VEC_W-1:0] den);
        lane_t lane;
        lane.spc = SPC_NONE;
        lane.x   = den;
        lane.y   = num;
        lane.acc = '0;
        if (num == '0) begin
            lane.spc = den[VEC_W-1] ? SPC_HALF : SPC_ZERO;
        end else if (den == '0) begin
            lane.spc = num[VEC_W-1] ? SPC_NEG_Q : SPC_POS_Q;
        end else if (den[VEC_W-1]) begin
            if (!num[VEC_W-1]) begin
                lane.x   = num;
                lane.y   = -den;
                lane.acc = QUARTER_TURN;
            end else begin
                lane.x   = -num;
                lane.y   = den;
                lane.acc = -QUARTER_TURN;
            end
        end
        return lane;
    endfunction

endpackage

[design/atilt_stream_if.sv]
// ----------------------------------------------------------------------------
// atilt_stream_if: valid/ready channel
// Carries one payload word per handshake from a source to a sink.
// ----------------------------------------------------------------------------
interface atilt_stream_if #(parameter type payload_t = logic);

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

[design/accel_tilt_angles_core.sv]
// ----------------------------------------------------------------------------
// accel_tilt_angles_core: pitch, roll and tilt flag from one accelerometer
// sample, through a square root row and a vectoring CORDIC row.
//
//   channel  | modport | word
//   ---------+---------+-----------------------------------------------
//   sample   | sink    | accel_x, accel_y, accel_z (signed 16 bits)
//   angles   | source  | pitch_angle, roll_angle, tilted
//   cfg      | sink    | tilt_threshold (15 bits), always ready
//
// One sample is taken every cycle while sample.ready is high. A result
// passes the sample and square registers, one root bit per cell over 24
// cells, a set-up register, one CORDIC cell per stage, the scaling
// registers and one output register.
// All stages move together; when the output stalls, a skid register takes
// the word in flight and sample.ready drops for as long as it is full.
// Reset clears all valid bits and loads the threshold with 3000.
// ----------------------------------------------------------------------------
module accel_tilt_angles_core #(
    parameter int CORDIC_STAGES = 16,
    parameter int SAMPLE_WIDTH  = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    atilt_stream_if.sink   sample,
    atilt_stream_if.source angles,
    atilt_stream_if.sink   cfg
);

    localparam int ROOT_W = atilt_pkg::ROOT_W;

    logic                               en;
    logic [atilt_pkg::THRESH_W-1:0]     thresh_reg;

    logic                               s0_valid_reg;
    logic signed [atilt_pkg::SAMPLE_BITS-1:0] s0_x_reg;
    logic signed [atilt_pkg::SAMPLE_BITS-1:0] s0_y_reg;
    logic signed [atilt_pkg::SAMPLE_BITS-1:0] s0_z_reg;

    logic                               s1_valid_reg;
    atilt_pkg::root_word_t              s1_word_reg;
    atilt_pkg::root_word_t              s1_word_next;

    logic                               sq_valid [ROOT_W+1];
    atilt_pkg::root_word_t              sq_word  [ROOT_W+1];

    logic                               prep_valid_reg;
    atilt_pkg::cordic_word_t            prep_word_reg;
    atilt_pkg::cordic_word_t            prep_word_next;

    logic                               cd_valid [CORDIC_STAGES+1];
    atilt_pkg::cordic_word_t            cd_word  [CORDIC_STAGES+1];

    logic                               fin_valid;
    atilt_pkg::result_t                 fin_word;

    logic                               out_valid_reg;
    logic                               out_valid_next;
    atilt_pkg::result_t                 out_word_reg;
    atilt_pkg::result_t                 out_word_next;
    logic                               skid_valid_reg;
    logic                               skid_valid_next;
    atilt_pkg::result_t                 skid_word_reg;
    atilt_pkg::result_t                 skid_word_next;

    function automatic logic signed [atilt_pkg::SAMPLE_BITS-1:0] sext(
        input logic [atilt_pkg::SAMPLE_BITS-1:0] raw
    );
        return atilt_pkg::SAMPLE_BITS'($signed(raw[SAMPLE_WIDTH-1:0]));
    endfunction

    assign en           = !skid_valid_reg;
    assign sample.ready = en;
    assign cfg.ready    = 1'b1;

    // Threshold register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= atilt_pkg::THRESH_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            thresh_reg <= cfg.data.tilt_threshold;
        end
    end

    // Squares and the radicand (x*x + z*z) * 2^16.
    always_comb
    begin
        logic signed [2*atilt_pkg::SAMPLE_BITS-1:0] xx;
        logic signed [2*atilt_pkg::SAMPLE_BITS-1:0] zz;
        logic [2*atilt_pkg::SAMPLE_BITS-1:0]        sq;
        xx = s0_x_reg * s0_x_reg;
        zz = s0_z_reg * s0_z_reg;
        sq = xx + zz;
        s1_word_next.rem  = {sq, 16'b0};
        s1_word_next.root = '0;
        s1_word_next.x    = s0_x_reg;
        s1_word_next.y    = s0_y_reg;
        s1_word_next.z    = s0_z_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg   <= 1'b0;
            s1_valid_reg   <= 1'b0;
            prep_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg   <= sample.valid;
            s1_valid_reg   <= s0_valid_reg;
            prep_valid_reg <= sq_valid[ROOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_x_reg      <= sext(sample.data.accel_x);
            s0_y_reg      <= sext(sample.data.accel_y);
            s0_z_reg      <= sext(sample.data.accel_z);
            s1_word_reg   <= s1_word_next;
            prep_word_reg <= prep_word_next;
        end
    end

    assign sq_valid[0] = s1_valid_reg;
    assign sq_word[0]  = s1_word_reg;

    // Square root row, most significant root bit first.
    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_sqrt
        atilt_sqrt_cell #(
            .BIT_POS (ROOT_W - 1 - j)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (sq_valid[j]),
            .in_word   (sq_word[j]),
            .out_valid (sq_valid[j+1]),
            .out_word  (sq_word[j+1])
        );
    end

    // Pitch = atan2(y * 2^8, root), roll = atan2(-x * 2^8, z * 2^8).
    always_comb
    begin
        logic signed [atilt_pkg::VEC_W-1:0] pn;
        logic signed [atilt_pkg::VEC_W-1:0] pd;
        logic signed [atilt_pkg::VEC_W-1:0] rn;
        logic signed [atilt_pkg::VEC_W-1:0] rd;
        pn = atilt_pkg::VEC_W'($signed(sq_word[ROOT_W].y)) <<< 8;
        pd = atilt_pkg::VEC_W'(sq_word[ROOT_W].root);
        rn = -(atilt_pkg::VEC_W'($signed(sq_word[ROOT_W].x)) <<< 8);
        rd = atilt_pkg::VEC_W'($signed(sq_word[ROOT_W].z)) <<< 8;
        prep_word_next.pitch = atilt_pkg::prep_lane(pn, pd);
        prep_word_next.roll  = atilt_pkg::prep_lane(rn, rd);
    end

    assign cd_valid[0] = prep_valid_reg;
    assign cd_word[0]  = prep_word_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        atilt_cordic_cell #(
            .STAGE (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (cd_valid[i]),
            .in_word   (cd_word[i]),
            .out_valid (cd_valid[i+1]),
            .out_word  (cd_word[i+1])
        );
    end

    atilt_finish u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (cd_valid[CORDIC_STAGES]),
        .in_word   (cd_word[CORDIC_STAGES]),
        .threshold (thresh_reg),
        .out_valid (fin_valid),
        .out_word  (fin_word)
    );

    // Output register with a skid register behind it.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_word_next   = out_word_reg;
        skid_valid_next = skid_valid_reg;
        skid_word_next  = skid_word_reg;
        if (!out_valid_reg || angles.ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_word_next   = skid_word_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = fin_valid;
                out_word_next  = fin_word;
            end
        end
        else if (en && fin_valid)
        begin
            skid_valid_next = 1'b1;
            skid_word_next  = fin_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

    assign angles.valid = out_valid_reg;
    assign angles.data  = out_word_reg;

`ifndef ASSERT_OFF
    // The skid register only fills behind a word that is already shown.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held without an output word");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !angles.ready))
        else $error("skid register filled while the output was free");

    assert property (@(posedge clk) disable iff (!rst_n)
        angles.valid |->
            ($signed(angles.data.pitch_angle) <= 9000)
            && ($signed(angles.data.pitch_angle) >= -9000)
            && ($signed(angles.data.roll_angle) <= 18000)
            && ($signed(angles.data.roll_angle) >= -18000))
        else $error("angle out of range");
`endif

endmodule

[design/atilt_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// atilt_sqrt_cell: one bit of the integer square root
// Decides root bit BIT_POS by comparing the running remainder with the
// increase of the square, and passes the word on to the next cell.
// ----------------------------------------------------------------------------
module atilt_sqrt_cell #(
    parameter int BIT_POS = 0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  atilt_pkg::root_word_t  in_word,
    output logic                   out_valid,
    output atilt_pkg::root_word_t  out_word
);

    logic                  valid_reg;
    atilt_pkg::root_word_t word_reg;
    atilt_pkg::root_word_t word_next;

    // (root + 2^k)^2 - root^2 = root * 2^(k+1) + 2^(2k)
    always_comb
    begin
        logic [atilt_pkg::RAD_W-1:0] cand;
        cand = (atilt_pkg::RAD_W'(in_word.root) << (BIT_POS + 1))
             | (atilt_pkg::RAD_W'(1) << (2 * BIT_POS));
        word_next = in_word;
        if (in_word.rem >= cand)
        begin
            word_next.rem           = in_word.rem - cand;
            word_next.root[BIT_POS] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

[design/atilt_cordic_cell.sv]
// ----------------------------------------------------------------------------
// atilt_cordic_cell: one vectoring CORDIC micro-rotation
// Rotates the pitch and roll vectors toward the x axis by atan(2^-STAGE)
// and updates both angle accumulators.
// ----------------------------------------------------------------------------
module atilt_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  atilt_pkg::cordic_word_t in_word,
    output logic                    out_valid,
    output atilt_pkg::cordic_word_t out_word
);

    logic                    valid_reg;
    atilt_pkg::cordic_word_t word_reg;
    atilt_pkg::cordic_word_t word_next;

    function automatic atilt_pkg::lane_t rotate(input atilt_pkg::lane_t lane);
        atilt_pkg::lane_t                  res;
        logic signed [atilt_pkg::VEC_W-1:0] x;
        logic signed [atilt_pkg::VEC_W-1:0] y;
        logic signed [atilt_pkg::VEC_W-1:0] sx;
        logic signed [atilt_pkg::VEC_W-1:0] sy;
        logic signed [atilt_pkg::ACC_W-1:0] acc;
        logic signed [atilt_pkg::ACC_W-1:0] step;
        x    = $signed(lane.x);
        y    = $signed(lane.y);
        acc  = $signed(lane.acc);
        sx   = x >>> STAGE;
        sy   = y >>> STAGE;
        step = atilt_pkg::atan_turn(STAGE);
        res  = lane;
        if (!y[atilt_pkg::VEC_W-1]) begin
            res.x   = x + sy;
            res.y   = y - sx;
            res.acc = acc + step;
        end else begin
            res.x   = x - sy;
            res.y   = y + sx;
            res.acc = acc - step;
        end
        return res;
    endfunction

    always_comb
    begin
        word_next.pitch = rotate(in_word.pitch);
        word_next.roll  = rotate(in_word.roll);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

[design/atilt_finish.sv]
// ----------------------------------------------------------------------------
// atilt_finish: angle scaling, clamping and tilt flag
// First stage scales the turn accumulators to rounded hundredths of a
// degree; second stage clamps, applies the sign and checks the threshold.
// ----------------------------------------------------------------------------
module atilt_finish (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  atilt_pkg::cordic_word_t         in_word,
    input  logic [atilt_pkg::THRESH_W-1:0]  threshold,
    output logic                            out_valid,
    output atilt_pkg::result_t              out_word
);

    localparam int PROD_W = atilt_pkg::ACC_W + 16;

    typedef struct packed {
        logic                         neg;
        logic [atilt_pkg::HUND_W-1:0] hund;
    } hund_t;

    logic               s1_valid_reg;
    hund_t              pitch_reg;
    hund_t              pitch_next;
    hund_t              roll_reg;
    hund_t              roll_next;
    logic               s2_valid_reg;
    atilt_pkg::result_t result_reg;
    atilt_pkg::result_t result_next;

    // |acc| * 36000 / 2^32, rounded half away from zero.
    function automatic hund_t to_hund(input atilt_pkg::lane_t lane);
        hund_t                              res;
        logic signed [atilt_pkg::ACC_W-1:0] acc;
        logic [atilt_pkg::ACC_W-1:0]        mag;
        logic [PROD_W-1:0]                  prod;
        acc  = $signed(lane.acc);
        mag  = acc[atilt_pkg::ACC_W-1] ? atilt_pkg::ACC_W'(-acc) : acc;
        prod = PROD_W'(mag) * PROD_W'(atilt_pkg::HUND_PER_TURN)
             + (PROD_W'(1) << 31);
        res.neg  = acc[atilt_pkg::ACC_W-1];
        res.hund = prod[32 +: atilt_pkg::HUND_W];
        case (lane.spc)
            atilt_pkg::SPC_ZERO:
            begin
                res.neg  = 1'b0;
                res.hund = '0;
            end
            atilt_pkg::SPC_HALF:
            begin
                res.neg  = 1'b0;
                res.hund = atilt_pkg::HALF_HUND;
            end
            atilt_pkg::SPC_POS_Q:
            begin
                res.neg  = 1'b0;
                res.hund = atilt_pkg::QUARTER_HUND;
            end
            atilt_pkg::SPC_NEG_Q:
            begin
                res.neg  = 1'b1;
                res.hund = atilt_pkg::QUARTER_HUND;
            end
            default:
            begin
                res.neg  = acc[atilt_pkg::ACC_W-1];
                res.hund = prod[32 +: atilt_pkg::HUND_W];
            end
        endcase
        return res;
    endfunction

    function automatic logic [atilt_pkg::MAG_W-1:0] clamp_mag(
        input logic [atilt_pkg::HUND_W-1:0] hund,
        input logic [atilt_pkg::HUND_W-1:0] lim
    );
        logic [atilt_pkg::HUND_W-1:0] val;
        val = (hund > lim) ? lim : hund;
        return val[atilt_pkg::MAG_W-1:0];
    endfunction

    always_comb
    begin
        pitch_next = to_hund(in_word.pitch);
        roll_next  = to_hund(in_word.roll);
    end

    always_comb
    begin
        logic [atilt_pkg::MAG_W-1:0] pm;
        logic [atilt_pkg::MAG_W-1:0] rm;
        pm = clamp_mag(pitch_reg.hund, atilt_pkg::PITCH_LIM);
        rm = clamp_mag(roll_reg.hund, atilt_pkg::ROLL_LIM);
        result_next.pitch_angle = pitch_reg.neg ? atilt_pkg::PITCH_W'(-pm)
                                                : atilt_pkg::PITCH_W'(pm);
        result_next.roll_angle  = roll_reg.neg ? -atilt_pkg::ROLL_W'(rm)
                                               : atilt_pkg::ROLL_W'(rm);
        result_next.tilted      = (pm > threshold) || (rm > threshold);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pitch_reg  <= pitch_next;
            roll_reg   <= roll_next;
            result_reg <= result_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_word  = result_reg;

endmodule
